>>> hdl/fcfl_pkg.sv
// Shared types, codes and constants for the fixed chunk free list allocator.
// Used by every module of the block but the link memory; depends on nothing.
package fcfl_pkg;

    localparam int MAX_CHUNKS_DEF = 1024;
    localparam int CNT_FIELD_W    = 17;
    localparam int ADDR_W         = 32;
    localparam int SHIFT_W        = 5;
    localparam int CCOUNT_W       = 11;
    localparam int STATUS_W       = 3;
    localparam int BYTES_W        = 31;
    localparam int CFG_IDX_W      = 2;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 72;

    localparam logic [SHIFT_W-1:0]  SHIFT_MIN       = 5'd3;
    localparam logic [SHIFT_W-1:0]  SHIFT_MAX       = 5'd20;
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET     = 5'd3;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET    = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EXHAUSTED  = 3'd1,
        ST_RANGE      = 3'd2,
        ST_MISALIGNED = 3'd3,
        ST_NONE       = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BASE   = 2'd0,
        REG_CHUNK_SHIFT = 2'd1,
        REG_CHUNK_COUNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                   recreate;
        logic [ADDR_W-1:0]      base;
        logic [SHIFT_W-1:0]     shift;
        logic [CNT_FIELD_W-1:0] count;
    } t_pool_cfg;

endpackage

>>> hdl/fcfl_link_ram.sv
// Synchronous link memory with one write port and one registered read port.
// Depends on nothing; sized by the parameters from the top level.
module fcfl_link_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/fcfl_cfg.sv
// Configuration registers and their clamped effective values.
// Depends on fcfl_pkg.
module fcfl_cfg #(
    parameter int MAX_CHUNKS = fcfl_pkg::MAX_CHUNKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fcfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    output fcfl_pkg::t_pool_cfg          o_cfg
);
    import fcfl_pkg::*;

    logic [ADDR_W-1:0]      r_pool_base;
    logic [SHIFT_W-1:0]     r_chunk_shift;
    logic [CCOUNT_W-1:0]    r_chunk_count;
    logic                   wr_fire;
    logic                   wr_known;
    logic [CNT_FIELD_W-1:0] eff_count;
    logic [SHIFT_W-1:0]     eff_shift;

    assign o_cfg_ready = 1'b1;
    assign wr_fire     = i_cfg_valid && o_cfg_ready;
    assign wr_known    = (i_cfg_index == REG_POOL_BASE) || (i_cfg_index == REG_CHUNK_SHIFT) ||
                         (i_cfg_index == REG_CHUNK_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_chunk_shift <= SHIFT_RESET;
            r_chunk_count <= CCOUNT_RESET;
        end else if (wr_fire) begin
            case (i_cfg_index)
                REG_POOL_BASE:   r_pool_base   <= i_cfg_data;
                REG_CHUNK_SHIFT: r_chunk_shift <= i_cfg_data[SHIFT_W-1:0];
                REG_CHUNK_COUNT: r_chunk_count <= i_cfg_data[CCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_chunk_shift < SHIFT_MIN) begin
            eff_shift = SHIFT_MIN;
        end else if (r_chunk_shift > SHIFT_MAX) begin
            eff_shift = SHIFT_MAX;
        end else begin
            eff_shift = r_chunk_shift;
        end
        if (r_chunk_count == '0) begin
            eff_count = CNT_FIELD_W'(1);
        end else if (32'(r_chunk_count) > 32'(MAX_CHUNKS)) begin
            eff_count = CNT_FIELD_W'(MAX_CHUNKS);
        end else begin
            eff_count = CNT_FIELD_W'(r_chunk_count);
        end
    end

    assign o_cfg.recreate = wr_fire && wr_known;
    assign o_cfg.base     = r_pool_base;
    assign o_cfg.shift    = eff_shift;
    assign o_cfg.count    = eff_count;

endmodule

>>> hdl/fixed_chunk_free_list_allocator.sv
// Top level of the fixed chunk free list allocator: request sequencer and result register.
// Depends on fcfl_pkg, fcfl_cfg and fcfl_link_ram.
//
// Each request transaction on the slave side yields exactly one result transaction on the
// master side. A free request, and an allocate that is served from the never-used chunks
// or finds the pool exhausted, is answered from IDLE; an allocate that pops the freed list
// goes through LINK, as the link of the popped chunk must come out of the synchronous link
// memory before the new list head is known. A new request is taken while the previous
// result waits in the output register only once that result is taken in the same cycle.
// The link memory needs no clearing after reset, since only pushed entries are read.
// Writing any known configuration register re-creates the pool with all chunks free; write
// it only while no request is in flight.
module fixed_chunk_free_list_allocator #(
    parameter int MAX_CHUNKS = fcfl_pkg::MAX_CHUNKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [31:0] address
    input  logic [fcfl_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] cmd
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] chunk_address, [34:32] status, [65:35] allocated_bytes, [66] pool_empty,
    // [71:67] zero
    output logic [fcfl_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import fcfl_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam logic [CNT_W-1:0] NULL_IDX = CNT_W'(MAX_CHUNKS);

    typedef enum logic [1:0] {
        IDLE = 2'b01,
        LINK = 2'b10
    } t_state;

    t_pool_cfg          cfg;
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_fresh, n_fresh;
    logic [CNT_W-1:0]   r_alloc, n_alloc;
    logic               r_m_tvalid, n_m_tvalid;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    t_status            r_status, n_status;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic               r_empty, n_empty;

    logic [CNT_W-1:0]   count;
    logic               s_fire;
    logic               head_valid;
    logic [CNT_W-1:0]   alloc_idx;
    logic [ADDR_W-1:0]  offset;
    logic [63:0]        pool_size;
    logic [ADDR_W-1:0]  mask;
    logic [CNT_W-1:0]   free_idx;
    logic [63:0]        bytes_wide;
    logic [CNT_W-1:0]   link;
    logic [CNT_W-1:0]   link_head;
    logic               wr_en;
    logic               rd_en;

    fcfl_cfg #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fcfl_link_ram #(
        .DEPTH (MAX_CHUNKS),
        .WIDTH (CNT_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_idx[IDX_W-1:0]),
        .i_wr_data (head_valid ? r_head : NULL_IDX),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head[IDX_W-1:0]),
        .o_rd_data (link)
    );

    assign count      = cfg.count[CNT_W-1:0];
    assign o_s_tready = (r_state == IDLE) && (!r_m_tvalid || i_m_tready);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign head_valid = r_head < count;
    assign alloc_idx  = head_valid ? r_head : r_fresh;
    assign offset     = i_s_tdata - cfg.base;
    assign pool_size  = 64'(count) << cfg.shift;
    assign mask       = (32'd1 << cfg.shift) - 32'd1;
    assign free_idx   = CNT_W'(offset >> cfg.shift);
    assign link_head  = (link < count) ? link : NULL_IDX;
    assign bytes_wide = 64'(n_alloc) << cfg.shift;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fresh    = r_fresh;
        n_alloc    = r_alloc;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_addr     = r_addr;
        n_status   = r_status;
        n_empty    = r_empty;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        if (cfg.recreate) begin
            n_head  = NULL_IDX;
            n_fresh = '0;
            n_alloc = '0;
            n_state = IDLE;
        end else begin
            case (r_state)
                IDLE: begin
                    if (s_fire) begin
                        n_addr   = '0;
                        n_status = ST_OK;
                        if (i_s_tuser == CMD_ALLOC) begin
                            if (head_valid) begin
                                rd_en   = 1'b1;
                                n_alloc = r_alloc + 1'b1;
                                n_addr  = cfg.base + (32'(alloc_idx) << cfg.shift);
                                n_state = LINK;
                            end else if (r_fresh < count) begin
                                n_fresh = r_fresh + 1'b1;
                                n_alloc = r_alloc + 1'b1;
                                n_addr  = cfg.base + (32'(alloc_idx) << cfg.shift);
                            end else begin
                                n_status = ST_EXHAUSTED;
                            end
                        end else begin
                            if (64'(offset) >= pool_size) begin
                                n_status = ST_RANGE;
                            end else if ((offset & mask) != '0) begin
                                n_status = ST_MISALIGNED;
                            end else if (r_alloc == '0) begin
                                n_status = ST_NONE;
                            end else begin
                                wr_en   = 1'b1;
                                n_alloc = r_alloc - 1'b1;
                                n_head  = free_idx;
                            end
                        end
                        if (n_state == IDLE) begin
                            n_m_tvalid = 1'b1;
                            n_empty    = (n_head >= count) && (n_fresh >= count);
                        end
                    end
                end
                LINK: begin
                    n_head     = link_head;
                    n_m_tvalid = 1'b1;
                    n_empty    = (link_head >= count) && (r_fresh >= count);
                    n_state    = IDLE;
                end
                default: begin
                    n_state = IDLE;
                end
            endcase
        end
    end

    assign n_bytes = bytes_wide[BYTES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= IDLE;
            r_head     <= NULL_IDX;
            r_fresh    <= '0;
            r_alloc    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_fresh    <= n_fresh;
            r_alloc    <= n_alloc;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_status <= n_status;
        r_empty  <= n_empty;
        if (s_fire) begin
            r_bytes <= n_bytes;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {5'd0, r_empty, r_bytes, r_status, r_addr};

endmodule

>>> hdl/fcfl_checker.sv
// Port-level checks for the fixed chunk free list allocator, bound to its top level.
// Depends on fcfl_pkg and fixed_chunk_free_list_allocator.
module fcfl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [fcfl_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import fcfl_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled result changed.");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[34:32] <= ST_NONE)
        else $error("Illegal status code.");

    a_failed_has_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[34:32] != ST_OK) |-> o_m_tdata[31:0] == '0)
        else $error("Failed request returned an address.");

    a_no_accept_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("Request taken while a result is stalled.");

endmodule

bind fixed_chunk_free_list_allocator fcfl_checker u_fcfl_checker (.*);

>>> verif/fcfl_reply_checker.sv
// Result checker for the fixed chunk free list allocator: follows the register,
// request and result channels, predicts each result and compares it field by field.
// Depends on fcfl_pkg only.
module fcfl_reply_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [fcfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [fcfl_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [fcfl_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_end_of_run,
    output int                             o_fail_count
);
    import fcfl_pkg::*;

    localparam int unsigned NO_CHUNK = MAX_CHUNKS_DEF;

    typedef struct packed {
        logic               pool_empty;
        logic [BYTES_W-1:0] allocated_bytes;
        t_status            status;
        logic [ADDR_W-1:0]  chunk_address;
    } t_chunk_reply;

    logic [ADDR_W-1:0]   pool_base;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [CCOUNT_W-1:0] count_reg;
    int unsigned         chunk_link [MAX_CHUNKS_DEF];
    int unsigned         list_head;
    int unsigned         fresh_used;
    int unsigned         chunks_held;
    t_chunk_reply        pending_replies [$];
    int                  fail_total = 0;
    logic                end_checked = 1'b0;

    assign o_fail_count = fail_total;

    function automatic int unsigned shift_in_use();
        if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
        if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
        return shift_reg;
    endfunction

    function automatic int unsigned count_in_use();
        if (count_reg == '0) return 1;
        if (count_reg > MAX_CHUNKS_DEF) return MAX_CHUNKS_DEF;
        return count_reg;
    endfunction

    function automatic void clear_pool();
        list_head   = NO_CHUNK;
        fresh_used  = 0;
        chunks_held = 0;
    endfunction

    function automatic t_chunk_reply serve_request(logic op, logic [ADDR_W-1:0] addr);
        int unsigned       shift;
        int unsigned       count;
        int unsigned       idx;
        logic              head_ok;
        logic              granted;
        logic [ADDR_W-1:0] offset;
        logic [63:0]       held_bytes;
        t_chunk_reply      r;
        shift   = shift_in_use();
        count   = count_in_use();
        head_ok = list_head < count;
        granted = 1'b0;
        idx     = 0;
        r       = '0;
        r.status = ST_OK;
        if (op == CMD_ALLOC) begin
            if (head_ok) begin
                idx       = list_head;
                list_head = chunk_link[idx];
                if (list_head >= count) list_head = NO_CHUNK;
                granted   = 1'b1;
            end else if (fresh_used < count) begin
                idx = fresh_used;
                fresh_used++;
                granted = 1'b1;
            end
            if (granted) begin
                chunks_held++;
                r.chunk_address = pool_base + ADDR_W'(idx << shift);
            end else begin
                r.status = ST_EXHAUSTED;
            end
        end else begin
            offset = addr - pool_base;
            if (64'(offset) >= (64'(count) << shift)) begin
                r.status = ST_RANGE;
            end else if ((offset & ((32'd1 << shift) - 32'd1)) != '0) begin
                r.status = ST_MISALIGNED;
            end else if (chunks_held == 0) begin
                r.status = ST_NONE;
            end else begin
                idx = offset >> shift;
                chunks_held--;
                chunk_link[idx] = head_ok ? list_head : NO_CHUNK;
                list_head = idx;
            end
        end
        held_bytes        = 64'(chunks_held) << shift;
        r.allocated_bytes = held_bytes[BYTES_W-1:0];
        r.pool_empty      = (list_head >= count) && (fresh_used >= count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_chunk_reply want;
        t_chunk_reply got;
        if (!i_rst_n) begin
            pool_base = '0;
            shift_reg = SHIFT_RESET;
            count_reg = CCOUNT_RESET;
            clear_pool();
            pending_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_chunk_reply'(i_m_tdata[$bits(t_chunk_reply)-1:0]);
                if (pending_replies.size() == 0) begin
                    $display("%0t: result transaction with no request waiting, got 0x%0h",
                             $time, i_m_tdata);
                    fail_total++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("chunk_address", want.chunk_address, got.chunk_address);
                    check_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
                    check_field("allocated_bytes", ADDR_W'(want.allocated_bytes),
                                ADDR_W'(got.allocated_bytes));
                    check_field("pool_empty", ADDR_W'(want.pool_empty),
                                ADDR_W'(got.pool_empty));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_replies.push_back(serve_request(i_s_tuser, i_s_tdata));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_POOL_BASE: begin
                        pool_base = i_cfg_data;
                        clear_pool();
                    end
                    REG_CHUNK_SHIFT: begin
                        shift_reg = i_cfg_data[SHIFT_W-1:0];
                        clear_pool();
                    end
                    REG_CHUNK_COUNT: begin
                        count_reg = i_cfg_data[CCOUNT_W-1:0];
                        clear_pool();
                    end
                    default: begin
                    end
                endcase
            end
            if (i_end_of_run && !end_checked) begin
                end_checked = 1'b1;
                if (pending_replies.size() != 0) begin
                    $display("%0t: %0d expected results never arrived, expected 0, got %0d",
                             $time, pending_replies.size(), pending_replies.size());
                    fail_total++;
                end
            end
        end
    end

endmodule

>>> verif/tb_fixed_chunk_free_list_allocator.sv
// Testbench top for the fixed chunk free list allocator: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on fcfl_pkg, fcfl_reply_checker and the allocator RTL.
module tb_fixed_chunk_free_list_allocator;
    import fcfl_pkg::*;

    localparam int                   CYCLE_LIMIT = 400000;
    localparam int                   PHASES      = 8;
    localparam int                   PHASE_ITEMS = 220;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [31:0]           i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  end_of_run  = 1'b0;
    int                    fail_count;

    int                    cycle_count   = 0;
    int                    n_sent        = 0;
    int                    n_done        = 0;
    int                    n_writes      = 0;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    alloc_pct     = 50;
    int                    status_seen [5] = '{default: 0};
    logic [ADDR_W-1:0]     held_chunks [$];
    logic [ADDR_W-1:0]     cur_base;
    int unsigned           cur_shift;
    int unsigned           cur_count;

    fixed_chunk_free_list_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    fcfl_reply_checker reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_end_of_run (end_of_run),
        .o_fail_count (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Outputs are stable from the falling edge on, so a transaction seen here is the one
    // that completes at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_done++;
            if (o_m_tdata[ADDR_W+STATUS_W-1:ADDR_W] <= ST_NONE) begin
                status_seen[o_m_tdata[ADDR_W+STATUS_W-1:ADDR_W]]++;
            end
            if (o_m_tdata[ADDR_W+STATUS_W-1:ADDR_W] == ST_OK && o_m_tdata[ADDR_W-1:0] != '0) begin
                held_chunks.push_back(o_m_tdata[ADDR_W-1:0]);
            end
        end
    end

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (n_done < n_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        n_writes++;
    endtask

    task automatic set_pool(input logic [31:0] base, input logic [SHIFT_W-1:0] shift,
                            input logic [CCOUNT_W-1:0] count);
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_CHUNK_SHIFT, 32'(shift));
        write_reg(REG_CHUNK_COUNT, 32'(count));
        cur_base  = base;
        cur_shift = (shift < SHIFT_MIN) ? SHIFT_MIN : (shift > SHIFT_MAX) ? SHIFT_MAX : shift;
        cur_count = (count == '0) ? 1 : (count > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : count;
        held_chunks.delete();
    endtask

    task automatic send_request(input t_cmd op, input logic [ADDR_W-1:0] addr);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= addr;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic random_request();
        int unsigned       roll;
        int unsigned       pick;
        logic [ADDR_W-1:0] addr;
        roll = $urandom_range(99);
        if (roll < alloc_pct || (roll < 88 && held_chunks.size() == 0)) begin
            send_request(CMD_ALLOC, $urandom());
        end else if (roll < 88) begin
            pick = $urandom_range(held_chunks.size() - 1);
            addr = held_chunks[pick];
            held_chunks.delete(pick);
            send_request(CMD_FREE, addr);
        end else begin
            case ($urandom_range(3))
                0: addr = $urandom();
                1: addr = cur_base + ADDR_W'($urandom_range(cur_count - 1) << cur_shift)
                          + $urandom_range(1, (32'd1 << cur_shift) - 1);
                2: addr = cur_base + ADDR_W'(cur_count << cur_shift)
                          + ADDR_W'($urandom_range(7) << cur_shift);
                default: addr = cur_base - $urandom_range(1, 64);
            endcase
            send_request(CMD_FREE, addr);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stall_pct = 30;

        // Reset pool: base 0, 8-byte chunks, 1024 of them.
        send_request(CMD_FREE, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0004);
        send_request(CMD_FREE, 32'h0000_2000);
        send_request(CMD_FREE, 32'hFFFF_FFF8);
        send_request(CMD_FREE, 32'h0000_0008);
        send_request(CMD_ALLOC, 32'h0000_0000);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0010);

        // Two chunks whose addresses wrap past the top of the address space.
        set_pool(32'hFFFF_FFF8, 5'd3, 11'd2);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0008);

        // Freeing a chunk that was never handed out puts it on the list anyway.
        set_pool(32'h0000_0000, 5'd3, 11'd4);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0018);
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_pool(32'h0000_0000, 5'd3, 11'd16);
                1: set_pool(32'hFFFF_FF00, 5'd5, 11'd64);
                2: set_pool($urandom(), 5'd31, 11'd1024);
                3: set_pool($urandom(), 5'd0, 11'd0);
                4: set_pool($urandom(), 5'd12, 11'd2047);
                5: set_pool(32'hFFFF_FFFF, 5'd20, 11'd4);
                6: set_pool($urandom(), 5'd20, 11'd1025);
                default: set_pool($urandom(), 5'($urandom_range(3, 20)),
                                  11'($urandom_range(1, 40)));
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 62;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 62;
                end
                default: begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            alloc_pct = $urandom_range(40, 60);
            send_request(CMD_FREE, cur_base + ADDR_W'($urandom_range(cur_count - 1) << cur_shift));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 2) wait_drained();
                random_request();
            end
        end

        wait_drained();
        end_of_run <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("Sent %0d requests and %0d register writes across %0d pool settings.",
                 n_sent, n_writes, PHASES + 2);
        $display("Results: ok %0d, exhausted %0d, out of range %0d, misaligned %0d, none held %0d.",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_RANGE],
                 status_seen[ST_MISALIGNED], status_seen[ST_NONE]);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
